>>> rtl/edge_token_interval_unpacker_macros.svh
// Assertion macros for the edge-token interval unpacker.
// Used by the top level; expects clk and arst_n in scope.
`ifndef EDGE_TOKEN_INTERVAL_UNPACKER_MACROS_SVH
`define EDGE_TOKEN_INTERVAL_UNPACKER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ETIU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ETIU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/etiu_pkg.sv
// Shared types and constants for the edge-token interval unpacker.
// No dependencies; imported by every module of the block.
package etiu_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned UNITS_W = 7;
	localparam int unsigned NIB_W   = 4;

	// Configuration register indexes.
	localparam logic [1:0] REG_UNIT_TOKEN       = 2'd0;
	localparam logic [1:0] REG_LONG_BLOCK_TOKEN = 2'd1;
	localparam logic [1:0] REG_LONG_TAIL_TOKEN  = 2'd2;
	localparam logic [1:0] REG_START_LEVEL      = 2'd3;

	// Register reset values.
	localparam logic [BYTE_W-1:0] UNIT_TOKEN_RST       = 8'd0;
	localparam logic [BYTE_W-1:0] LONG_BLOCK_TOKEN_RST = 8'd1;
	localparam logic [BYTE_W-1:0] LONG_TAIL_TOKEN_RST  = 8'd2;
	localparam logic              START_LEVEL_RST      = 1'b0;

	// Legal range of a wide interval byte.
	localparam logic [BYTE_W-1:0] WIDE_MIN = 8'd16;
	localparam logic [BYTE_W-1:0] WIDE_MAX = 8'd127;

	typedef enum logic [1:0] {
		KIND_INTERVAL = 2'd0,
		KIND_BREAK    = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_UNIT   = 3'b010,
		MODE_TAIL   = 3'b100
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic [UNITS_W-1:0] units;
		logic               level;
		logic               last;
	} result_t;

	typedef struct packed {
		mode_t mode;
		logic  level;
		logic  err;
	} parse_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] unit_token;
		logic [BYTE_W-1:0] long_block_token;
		logic [BYTE_W-1:0] long_tail_token;
	} tokens_t;

	// Decoder outcome for one byte: result count, both slots and next state.
	typedef struct packed {
		logic [1:0]   cnt;
		result_t      res0;
		result_t      res1;
		parse_state_t nxt;
	} decode_t;

endpackage

>>> rtl/etiu_decode.sv
// Combinational decode of one token byte against the parse state.
// Depends on etiu_pkg.
module etiu_decode (
	input  logic [etiu_pkg::BYTE_W-1:0] token_byte,
	input  etiu_pkg::parse_state_t      cur,
	input  etiu_pkg::tokens_t           tokens,
	output etiu_pkg::decode_t           dec
);
	import etiu_pkg::*;

	logic [NIB_W-1:0] hi;
	logic [NIB_W-1:0] lo;
	result_t          err_res;

	assign hi = token_byte[BYTE_W-1:NIB_W];
	assign lo = token_byte[NIB_W-1:0];

	always_comb begin
		err_res.kind  = KIND_ERROR;
		err_res.units = '0;
		err_res.level = cur.level;
		err_res.last  = 1'b1;
	end

	// Mode-dependent interpretation of the byte.
	always_comb begin
		dec.cnt       = 2'd1;
		dec.res0      = err_res;
		dec.res1      = err_res;
		dec.nxt       = cur;
		dec.nxt.mode  = MODE_NORMAL;
		if (cur.err) begin
			// A sticky error answers every byte and changes nothing else.
			dec.nxt = cur;
		end else begin
			unique case (cur.mode)
				MODE_UNIT: begin
					if ((token_byte < WIDE_MIN) || (token_byte > WIDE_MAX)) begin
						dec.nxt.err = 1'b1;
					end else begin
						dec.res0.kind  = KIND_INTERVAL;
						dec.res0.units = token_byte[UNITS_W-1:0];
						dec.nxt.level  = ~cur.level;
					end
				end
				MODE_TAIL: begin
					dec.res0.kind = KIND_BREAK;
					dec.nxt.level = ~cur.level;
				end
				default: begin
					// Normal mode: tokens first, in priority order, then nibbles.
					priority if (token_byte == tokens.unit_token) begin
						dec.cnt      = 2'd0;
						dec.nxt.mode = MODE_UNIT;
					end else if (token_byte == tokens.long_block_token) begin
						dec.res0.kind = KIND_BREAK;
					end else if (token_byte == tokens.long_tail_token) begin
						dec.cnt      = 2'd0;
						dec.nxt.mode = MODE_TAIL;
					end else if (hi == '0) begin
						dec.nxt.err = 1'b1;
					end else begin
						dec.res0.kind  = KIND_INTERVAL;
						dec.res0.units = UNITS_W'(hi);
						dec.res0.last  = (lo == '0);
						dec.res1.kind  = KIND_INTERVAL;
						dec.res1.units = UNITS_W'(lo);
						dec.res1.level = ~cur.level;
						if (lo == '0) begin
							dec.nxt.level = ~cur.level;
						end else begin
							// Two toggles leave the level where it was.
							dec.cnt = 2'd2;
						end
					end
				end
			endcase
		end
	end

endmodule

>>> rtl/etiu_out_buf.sv
// Two-slot result register that presents the results of one byte in order.
// Depends on etiu_pkg.
module etiu_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              two,
	input  etiu_pkg::result_t res0,
	input  etiu_pkg::result_t res1,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output etiu_pkg::result_t res
);
	import etiu_pkg::*;

	logic    valid_q;
	logic    two_q;
	logic    sel_q;
	result_t r0_q;
	result_t r1_q;
	logic    take;
	logic    last_slot;

	assign take      = valid_q && out_ready;
	assign last_slot = !two_q || sel_q;
	assign free      = !valid_q || (take && last_slot);
	assign out_valid = valid_q;
	assign res       = sel_q ? r1_q : r0_q;

	// Slot control: load a fresh pair, or step through the held one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			two_q   <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			two_q   <= two;
			sel_q   <= 1'b0;
		end else if (take) begin
			if (last_slot) begin
				valid_q <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= res0;
			r1_q <= res1;
		end
	end

endmodule

>>> rtl/edge_token_interval_unpacker.sv
// Channel   | Signals                                  | Moves
// ----------+------------------------------------------+------------------------------
// in        | in_valid, in_ready, token_byte           | one token byte per request
// out       | out_valid, out_ready, event_kind,        | one interval, break or error
//           | interval_units, pulse_level, last_of_run | result per request
// cfg       | cfg_valid, cfg_ready, cfg_index,cfg_data | one register write per request
//
// A byte enters an input register, is decoded from there and its results land in
// a two-slot result register. One byte is taken per cycle while the result
// register can accept its results; a byte with two intervals holds the result
// register until both are taken, so the output port sets the rate at one result a cycle.
// Token bytes with no result pass through without using the result register.
// Reset returns the parse state, the error flag and the configuration registers to their reset values.
// Depends on etiu_pkg, etiu_decode, etiu_out_buf and the macros header.
`include "edge_token_interval_unpacker_macros.svh"

module edge_token_interval_unpacker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [etiu_pkg::BYTE_W-1:0] token_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  event_kind,
	output logic [etiu_pkg::UNITS_W-1:0] interval_units,
	output logic                        pulse_level,
	output logic                        last_of_run,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [etiu_pkg::BYTE_W-1:0] cfg_data
);
	import etiu_pkg::*;

	logic              byte_v_s1;
	logic [BYTE_W-1:0] byte_s1;
	parse_state_t      state_q;
	tokens_t           tokens_q;
	decode_t           dec;
	logic              buf_free;
	logic              adv;
	logic              cfg_wr;
	result_t           res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// The staged byte moves on when it has no result or the result slots free up.
	assign adv      = byte_v_s1 && ((dec.cnt == 2'd0) || buf_free);
	assign in_ready = !byte_v_s1 || adv;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= token_byte;
		end
	end

	// Token registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens_q.unit_token       <= UNIT_TOKEN_RST;
			tokens_q.long_block_token <= LONG_BLOCK_TOKEN_RST;
			tokens_q.long_tail_token  <= LONG_TAIL_TOKEN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_UNIT_TOKEN:       tokens_q.unit_token       <= cfg_data;
				REG_LONG_BLOCK_TOKEN: tokens_q.long_block_token <= cfg_data;
				REG_LONG_TAIL_TOKEN:  tokens_q.long_tail_token  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parse state; a start level write loads the current level directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= MODE_NORMAL;
			state_q.level <= START_LEVEL_RST;
			state_q.err   <= 1'b0;
		end else begin
			if (adv) begin
				state_q.mode <= dec.nxt.mode;
				state_q.err  <= dec.nxt.err;
			end
			if (cfg_wr && (cfg_index == REG_START_LEVEL)) begin
				state_q.level <= cfg_data[0];
			end else if (adv) begin
				state_q.level <= dec.nxt.level;
			end
		end
	end

	etiu_decode u_decode (
		.token_byte (byte_s1),
		.cur        (state_q),
		.tokens     (tokens_q),
		.dec        (dec)
	);

	etiu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && (dec.cnt != 2'd0)),
		.two       (dec.cnt == 2'd2),
		.res0      (dec.res0),
		.res1      (dec.res1),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign event_kind     = res.kind;
	assign interval_units = res.units;
	assign pulse_level    = res.level;
	assign last_of_run    = res.last;

	// Checks on the block's own logic.
	`ETIU_ASSERT_NEXT(a_err_sticky, state_q.err, state_q.err, "error flag cleared without reset")
	`ETIU_ASSERT_NOW(a_first_is_interval, out_valid && !last_of_run, event_kind == KIND_INTERVAL, "non-final result is not an interval")
	`ETIU_ASSERT_NOW(a_stall_has_byte, !in_ready, byte_v_s1 && !buf_free, "input stalled without a waiting byte")

endmodule
